[src/ioct_pkg.sv]
// ============================================================================
// ioct_pkg
// Shared types and codes for the in-flight offset commit tracker.
// ============================================================================
package ioct_pkg;

    localparam int OffsetW = 63;

    // request codes on the input channel
    localparam logic [1:0] ReqDeliver = 2'd0;
    localparam logic [1:0] ReqAck     = 2'd1;
    localparam logic [1:0] ReqCommit  = 2'd2;

    typedef logic [OffsetW-1:0] offset_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t op;
        offset_t  offset;
    } cell_cmd_t;

    // contents handed between neighboring cells
    typedef struct packed {
        logic    valid;
        offset_t offset;
    } cell_link_t;

endpackage

[src/ioct_in_if.sv]
// ============================================================================
// ioct_in_if
// Request channel: request code and record offset.
// ============================================================================
interface ioct_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    ioct_pkg::offset_t offset;

    modport source (output valid, output req_type, output offset, input ready);
    modport sink   (input valid, input req_type, input offset, output ready);
endinterface

[src/ioct_out_if.sv]
// ============================================================================
// ioct_out_if
// Result channel: committable offset, reject flag and in-flight count.
// ============================================================================
interface ioct_out_if #(
    parameter int COUNT_W = 7
);
    logic               valid;
    logic               ready;
    logic               commit_valid;
    ioct_pkg::offset_t  commit_offset;
    logic               table_full_reject;
    logic [COUNT_W-1:0] in_flight_count;

    modport source (output valid, output commit_valid, output commit_offset,
                    output table_full_reject, output in_flight_count, input ready);
    modport sink   (input valid, input commit_valid, input commit_offset,
                    input table_full_reject, input in_flight_count, output ready);
endinterface

[src/ioct_cell.sv]
// ============================================================================
// ioct_cell
// One entry of the sorted chain. Valid entries sit packed at the head in
// ascending order; an insert shifts the tail right, a remove shifts it left.
// ============================================================================
module ioct_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ioct_pkg::cell_cmd_t  cmd,
    input  ioct_pkg::cell_link_t left,
    input  logic                 left_lt,
    input  ioct_pkg::cell_link_t right,
    output ioct_pkg::cell_link_t here,
    output logic                 lt,
    output logic                 match
);

    logic              valid_reg;
    logic              valid_next;
    ioct_pkg::offset_t offset_reg;
    ioct_pkg::offset_t offset_next;

    assign lt    = valid_reg && (offset_reg < cmd.offset);
    assign match = valid_reg && (offset_reg == cmd.offset);

    assign here.valid  = valid_reg;
    assign here.offset = offset_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        offset_next = offset_reg;
        case (cmd.op)
            ioct_pkg::CELL_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        valid_next  = 1'b1;
                        offset_next = cmd.offset;
                    end
                    else
                    begin
                        valid_next  = left.valid;
                        offset_next = left.offset;
                    end
                end
            end
            ioct_pkg::CELL_REMOVE:
            begin
                if (!lt)
                begin
                    valid_next  = right.valid;
                    offset_next = right.offset;
                end
            end
            default:
            begin
                valid_next  = valid_reg;
                offset_next = offset_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
    end

endmodule

[src/inflight_offset_commit_tracker.sv]
// ============================================================================
// inflight_offset_commit_tracker
// Keeps delivered but unacknowledged offsets in a sorted chain of cells and
// reports the lowest one (or the read position) as the committable offset.
// ============================================================================
//  channel  dir  payload                                          handshake
//  in       in   req_type, offset                                 valid/ready
//  out      out  commit_valid, commit_offset, table_full_reject,  valid/ready
//                in_flight_count
//
//  The chain updates at the accept edge; the result is built from the chain
//  head in the next cycle, unless out stalls with a result still held in
//  the output register. in.ready stays low from the accept until the
//  result is loaded into the output register.
//  Reset empties the chain at once (valid bits only); no clearing pass.
// ============================================================================
module inflight_offset_commit_tracker #(
    parameter int IN_FLIGHT_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ioct_in_if.sink    in,
    ioct_out_if.source out
);

    localparam int CountW = $clog2(IN_FLIGHT_DEPTH + 1);

    ioct_pkg::cell_cmd_t  cmd;
    ioct_pkg::cell_link_t cells    [IN_FLIGHT_DEPTH];
    ioct_pkg::cell_link_t right_in [IN_FLIGHT_DEPTH];
    ioct_pkg::cell_link_t left_in  [IN_FLIGHT_DEPTH];
    logic [IN_FLIGHT_DEPTH-1:0] lt_vec;
    logic [IN_FLIGHT_DEPTH-1:0] match_vec;
    logic [IN_FLIGHT_DEPTH-1:0] left_lt_vec;

    logic              accept;
    logic              found;
    logic              full;
    logic              do_insert;
    logic              do_remove;
    logic              reject;
    ioct_pkg::offset_t off_inc;
    logic              raise;
    ioct_pkg::offset_t raise_val;

    logic              pos_vld_reg;
    ioct_pkg::offset_t pos_reg;
    logic              cmt_vld_reg;
    ioct_pkg::offset_t cmt_reg;
    logic [CountW-1:0] count_reg;
    logic              pend_reg;
    logic              reject_reg;

    logic              out_valid_reg;
    logic              commit_valid_reg;
    ioct_pkg::offset_t commit_offset_reg;
    logic              table_full_reject_reg;
    logic [CountW-1:0] in_flight_count_reg;

    logic              load_out;
    logic              next_vld;
    ioct_pkg::offset_t next_val;

    assign accept = in.valid && in.ready;
    assign found  = |match_vec;
    assign full   = (count_reg == CountW'(IN_FLIGHT_DEPTH));

    assign do_insert = accept && (in.req_type == ioct_pkg::ReqDeliver) && !found && !full;
    assign do_remove = accept && (in.req_type == ioct_pkg::ReqAck) && found;
    assign reject    = (in.req_type == ioct_pkg::ReqDeliver) && !found && full;

    always_comb
    begin
        cmd.offset = in.offset;
        if (do_insert)
        begin
            cmd.op = ioct_pkg::CELL_INSERT;
        end
        else if (do_remove)
        begin
            cmd.op = ioct_pkg::CELL_REMOVE;
        end
        else
        begin
            cmd.op = ioct_pkg::CELL_HOLD;
        end
    end

    genvar g;
    generate
        for (g = 0; g < IN_FLIGHT_DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign left_in[g]     = '0;
                assign left_lt_vec[g] = 1'b1;
            end
            else
            begin : g_body
                assign left_in[g]     = cells[g-1];
                assign left_lt_vec[g] = lt_vec[g-1];
            end
            if (g == IN_FLIGHT_DEPTH - 1)
            begin : g_tail
                assign right_in[g] = '0;
            end
            else
            begin : g_mid
                assign right_in[g] = cells[g+1];
            end

            ioct_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cmd     (cmd),
                .left    (left_in[g]),
                .left_lt (left_lt_vec[g]),
                .right   (right_in[g]),
                .here    (cells[g]),
                .lt      (lt_vec[g]),
                .match   (match_vec[g])
            );
        end
    endgenerate

    // offset plus one, saturating at the top of the range
    assign off_inc = (&in.offset) ? in.offset : in.offset + ioct_pkg::offset_t'(1);

    always_comb
    begin
        raise_val = in.offset;
        raise     = 1'b0;
        case (in.req_type)
            ioct_pkg::ReqDeliver:
            begin
                raise_val = off_inc;
                raise     = !reject;
            end
            ioct_pkg::ReqCommit:
            begin
                raise_val = in.offset;
                raise     = 1'b1;
            end
            default:
            begin
                raise_val = in.offset;
                raise     = 1'b0;
            end
        endcase
    end

    // result from the updated chain head, or the read position when the chain is empty
    assign next_vld = cells[0].valid || pos_vld_reg;
    assign next_val = cells[0].valid ? cells[0].offset : pos_reg;
    assign load_out = pend_reg && (!out_valid_reg || out.ready);

    assign in.ready = !pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_vld_reg   <= 1'b0;
            cmt_vld_reg   <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= 1'b1;
                if (raise && (!pos_vld_reg || raise_val > pos_reg))
                begin
                    pos_vld_reg <= 1'b1;
                end
                if (in.req_type == ioct_pkg::ReqCommit)
                begin
                    cmt_vld_reg <= 1'b1;
                end
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end

            if (do_insert)
            begin
                count_reg <= count_reg + CountW'(1);
            end
            else if (do_remove)
            begin
                count_reg <= count_reg - CountW'(1);
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reject_reg <= reject;
            if (raise && (!pos_vld_reg || raise_val > pos_reg))
            begin
                pos_reg <= raise_val;
            end
            if (in.req_type == ioct_pkg::ReqCommit)
            begin
                cmt_reg <= in.offset;
            end
        end
        if (load_out)
        begin
            commit_valid_reg      <= next_vld && (!cmt_vld_reg || next_val > cmt_reg);
            commit_offset_reg     <= next_vld ? next_val : '0;
            table_full_reject_reg <= reject_reg;
            in_flight_count_reg   <= count_reg;
        end
    end

    assign out.valid             = out_valid_reg;
    assign out.commit_valid      = commit_valid_reg;
    assign out.commit_offset     = commit_offset_reg;
    assign out.table_full_reject = table_full_reject_reg;
    assign out.in_flight_count   = in_flight_count_reg;

endmodule

[src/ioct_checker.sv]
// ============================================================================
// ioct_checker
// Port-level checks for the in-flight offset commit tracker, bound to the top.
// ============================================================================
module ioct_checker #(
    parameter int IN_FLIGHT_DEPTH = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 table_full_reject,
    input logic [$clog2(IN_FLIGHT_DEPTH+1)-1:0] in_flight_count
);

    localparam int CountW = $clog2(IN_FLIGHT_DEPTH + 1);

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one transaction in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_flight_count <= CountW'(IN_FLIGHT_DEPTH))
        else $error("in-flight count above depth");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full_reject |-> in_flight_count == CountW'(IN_FLIGHT_DEPTH))
        else $error("reject flagged with free entries");

endmodule

bind inflight_offset_commit_tracker ioct_checker #(
    .IN_FLIGHT_DEPTH (IN_FLIGHT_DEPTH)
) u_ioct_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in.valid),
    .in_ready          (in.ready),
    .out_valid         (out.valid),
    .out_ready         (out.ready),
    .table_full_reject (out.table_full_reject),
    .in_flight_count   (out.in_flight_count)
);

[verif/ioct_tb_pkg.sv]
// ============================================================================
// ioct_tb_pkg
// Scoreboard for the in-flight offset commit tracker: keeps its own copy of
// the in-flight table, read position and committed offset, queues the
// expected status for every accepted request and checks each result.
// ============================================================================
package ioct_tb_pkg;

    localparam int                TableDepth  = 64;
    localparam int                ReportLimit = 10;
    localparam logic [1:0]        ReqUnused   = 2'd3;
    localparam ioct_pkg::offset_t OffsetMax   = {ioct_pkg::OffsetW{1'b1}};
    localparam longint            PosMax      = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic              commit_valid;
        ioct_pkg::offset_t commit_offset;
        logic              table_full_reject;
        logic [6:0]        in_flight_count;
    } commit_status_t;

    class commit_scoreboard;

        ioct_pkg::offset_t held_offset[TableDepth];
        bit                held_valid[TableDepth];
        longint            read_pos;
        longint            committed;
        commit_status_t    status_q[$];

        int n_req;
        int n_checked;
        int n_mismatch;
        int n_refused;
        int n_ack_hit;

        function new();
            foreach (held_valid[i])
            begin
                held_valid[i]  = 1'b0;
                held_offset[i] = '0;
            end
            read_pos   = -1;
            committed  = -1;
            n_req      = 0;
            n_checked  = 0;
            n_mismatch = 0;
            n_refused  = 0;
            n_ack_hit  = 0;
        endfunction

        function int find_held(ioct_pkg::offset_t off);
            foreach (held_valid[i])
                if (held_valid[i] && held_offset[i] == off)
                    return i;
            return -1;
        endfunction

        function int find_free();
            foreach (held_valid[i])
                if (!held_valid[i])
                    return i;
            return -1;
        endfunction

        function void raise_pos(longint v);
            if (v > read_pos)
                read_pos = v;
        endfunction

        function int live_count();
            int cnt;
            cnt = 0;
            foreach (held_valid[i])
                if (held_valid[i])
                    cnt++;
            return cnt;
        endfunction

        // random offset currently in flight; caller makes sure one exists
        function ioct_pkg::offset_t pick_live();
            int idx;
            idx = $urandom_range(TableDepth - 1);
            while (!held_valid[idx])
                idx = (idx + 1) % TableDepth;
            return held_offset[idx];
        endfunction

        function commit_status_t status_now(bit refused);
            commit_status_t    s;
            bit                any;
            ioct_pkg::offset_t low;
            int                cnt;
            longint            nxt;
            any = 1'b0;
            low = '0;
            cnt = 0;
            foreach (held_valid[i])
                if (held_valid[i])
                begin
                    cnt++;
                    if (!any || held_offset[i] < low)
                        low = held_offset[i];
                    any = 1'b1;
                end
            nxt = any ? longint'({1'b0, low}) : read_pos;
            s = '0;
            // negative committable value reports as zero, not valid
            if (nxt >= 0)
            begin
                s.commit_valid  = (nxt > committed);
                s.commit_offset = ioct_pkg::offset_t'(nxt);
            end
            s.table_full_reject = refused;
            s.in_flight_count   = 7'(cnt);
            return s;
        endfunction

        function void note_request(logic [1:0] code, ioct_pkg::offset_t off);
            int slot;
            bit refused;
            refused = 1'b0;
            n_req++;
            case (code)
                ioct_pkg::ReqDeliver:
                begin
                    slot = find_held(off);
                    if (slot < 0)
                    begin
                        slot = find_free();
                        if (slot < 0)
                            refused = 1'b1;
                        else
                        begin
                            held_offset[slot] = off;
                            held_valid[slot]  = 1'b1;
                        end
                    end
                    // duplicates still move the position, refusals do not
                    if (!refused)
                        raise_pos((off == OffsetMax) ? PosMax : longint'({1'b0, off}) + 1);
                end
                ioct_pkg::ReqAck:
                begin
                    slot = find_held(off);
                    if (slot >= 0)
                    begin
                        held_valid[slot] = 1'b0;
                        n_ack_hit++;
                    end
                end
                ioct_pkg::ReqCommit:
                begin
                    committed = longint'({1'b0, off});
                    raise_pos(committed);
                end
                default: ;
            endcase
            if (refused)
                n_refused++;
            status_q = {status_q, status_now(refused)};
        endfunction

        function void check_result(commit_status_t got);
            commit_status_t want;
            if (status_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= ReportLimit)
                    $display("%t: result with nothing expected: valid=%0b off=%h rej=%0b cnt=%0d",
                             $realtime, got.commit_valid, got.commit_offset,
                             got.table_full_reject, got.in_flight_count);
                return;
            end
            want = status_q.pop_front();
            n_checked++;
            if (got !== want)
            begin
                n_mismatch++;
                if (n_mismatch <= ReportLimit)
                    $display({"%t: result %0d mismatch: exp valid=%0b off=%h rej=%0b cnt=%0d,",
                              " got valid=%0b off=%h rej=%0b cnt=%0d"},
                             $realtime, n_checked,
                             want.commit_valid, want.commit_offset,
                             want.table_full_reject, want.in_flight_count,
                             got.commit_valid, got.commit_offset,
                             got.table_full_reject, got.in_flight_count);
            end
        endfunction

        function int waiting();
            return status_q.size();
        endfunction

    endclass

endpackage

[verif/testbench.sv]
// ============================================================================
// testbench
// Drives request transactions into the offset commit tracker under several
// idle/stall mixes, predicts each status with the scoreboard and checks every
// result in order. Directed corner cases first, then random traffic shaped to
// fill, drain and churn the in-flight table, then a few top-of-range cases.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems   = 1650;
    localparam int BlockItems    = 55;
    localparam int DrainCycles   = 8;
    localparam int WatchdogLimit = 4000;

    typedef enum int {
        MixFill,
        MixDrain,
        MixBalanced
    } traffic_mix_t;

    logic clk;
    logic rst_n;

    ioct_in_if              in_ch ();
    ioct_out_if #(.COUNT_W(7)) out_ch ();

    inflight_offset_commit_tracker #(
        .IN_FLIGHT_DEPTH(ioct_tb_pkg::TableDepth)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    ioct_tb_pkg::commit_scoreboard sb;
    int src_idle_pct;
    int snk_stall_pct;
    int idle_cycles;
    int random_sent;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: check accepted transactions, then pick next ready
    always @(posedge clk)
    begin
        ioct_tb_pkg::commit_status_t seen;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.commit_valid      = out_ch.commit_valid;
            seen.commit_offset     = out_ch.commit_offset;
            seen.table_full_reject = out_ch.table_full_reject;
            seen.in_flight_count   = out_ch.in_flight_count;
            sb.check_result(seen);
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WatchdogLimit)
            begin
                $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
                $display("inflight_offset_commit_tracker verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(input logic [1:0] code, input ioct_pkg::offset_t off);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= code;
        in_ch.offset   <= off;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(code, off);
    endtask

    function automatic ioct_pkg::offset_t wide_random();
        return ioct_pkg::offset_t'({$urandom, $urandom});
    endfunction

    // next offset of the delivery stream, just at or above the read position (0 to 1000 near the top of the range)
    function automatic ioct_pkg::offset_t stream_offset();
        longint base;
        base = (sb.read_pos < 0) ? 0 : sb.read_pos;
        if (base > ioct_tb_pkg::PosMax - 4096)
            return ioct_pkg::offset_t'($urandom_range(1000));
        return ioct_pkg::offset_t'(base + $urandom_range(2));
    endfunction

    task automatic random_block(input traffic_mix_t mix, input int n);
        int                          deliver_pct;
        int                          ack_pct;
        int                          r;
        logic [1:0]                  code;
        ioct_pkg::offset_t           off;
        ioct_pkg::offset_t           low;
        longint                      pos;
        ioct_tb_pkg::commit_status_t st;
        case (mix)
            MixFill:  begin deliver_pct = 80; ack_pct = 8;  end
            MixDrain: begin deliver_pct = 30; ack_pct = 56; end
            default:  begin deliver_pct = 48; ack_pct = 36; end
        endcase
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 6)
            begin
                // noise: any code, full-width offset
                code = 2'($urandom_range(3));
                off  = wide_random();
            end
            else if (r < 6 + deliver_pct)
            begin
                code = ioct_pkg::ReqDeliver;
                r    = $urandom_range(99);
                pos  = (sb.read_pos < 0) ? 0 : sb.read_pos;
                if (r < 6 && sb.live_count() > 0)
                    off = sb.pick_live();
                else if (r < 12)
                    off = ioct_pkg::offset_t'((pos > 200) ? pos - $urandom_range(1, 200) : 0);
                else
                    off = stream_offset();
            end
            else if (r < 6 + deliver_pct + ack_pct)
            begin
                code = ioct_pkg::ReqAck;
                if (sb.live_count() > 0 && $urandom_range(9) != 0)
                    off = sb.pick_live();
                else
                    off = stream_offset();
            end
            else
            begin
                code = ioct_pkg::ReqCommit;
                st   = sb.status_now(1'b0);
                low  = st.commit_offset;
                r    = $urandom_range(99);
                if (r < 60)
                    off = low;
                else if (r < 80)
                    off = stream_offset() + ioct_pkg::offset_t'($urandom_range(3));
                else
                    off = (low > 20) ? low - ioct_pkg::offset_t'($urandom_range(1, 20)) : '0;
            end
            send_req(code, off);
            if (code != ioct_tb_pkg::ReqUnused)
                random_sent++;
        end
    endtask

    initial
    begin
        int phase;
        sb            = new();
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.req_type = ioct_pkg::ReqDeliver;
        in_ch.offset  = '0;
        out_ch.ready  = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        idle_cycles   = 0;
        random_sent   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, duplicates, unknown acks, commits moving back
        send_req(ioct_pkg::ReqAck, '0);
        send_req(ioct_tb_pkg::ReqUnused, ioct_pkg::offset_t'(17));
        send_req(ioct_pkg::ReqDeliver, '0);
        send_req(ioct_pkg::ReqDeliver, '0);
        send_req(ioct_pkg::ReqDeliver, ioct_pkg::offset_t'(5));
        send_req(ioct_pkg::ReqDeliver, ioct_pkg::offset_t'(3));
        send_req(ioct_pkg::ReqAck, '0);
        send_req(ioct_pkg::ReqAck, '0);
        send_req(ioct_pkg::ReqCommit, ioct_pkg::offset_t'(2));
        send_req(ioct_pkg::ReqCommit, ioct_pkg::offset_t'(4));
        send_req(ioct_pkg::ReqCommit, ioct_pkg::offset_t'(1));
        send_req(ioct_pkg::ReqAck, ioct_pkg::offset_t'(3));
        send_req(ioct_pkg::ReqAck, ioct_pkg::offset_t'(5));
        send_req(ioct_tb_pkg::ReqUnused, ioct_tb_pkg::OffsetMax);

        // random traffic, rotating idle/stall mixes every block
        phase = 0;
        while (random_sent < RandomItems)
        begin
            case (phase % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 76; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 76; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            random_block(traffic_mix_t'($urandom_range(2)), BlockItems);
            phase++;
        end

        // top of the offset range last: the position cannot come back down
        src_idle_pct  = 21;
        snk_stall_pct = 21;
        send_req(ioct_pkg::ReqDeliver,
                 {(ioct_pkg::OffsetW / 2){2'b10}} | ioct_pkg::offset_t'(0));
        send_req(ioct_pkg::ReqDeliver,
                 ioct_pkg::offset_t'({(ioct_pkg::OffsetW / 2 + 1){2'b01}}));
        send_req(ioct_pkg::ReqDeliver, ioct_tb_pkg::OffsetMax);
        send_req(ioct_pkg::ReqDeliver, ioct_tb_pkg::OffsetMax);
        send_req(ioct_pkg::ReqAck, ioct_tb_pkg::OffsetMax);
        send_req(ioct_pkg::ReqCommit, ioct_tb_pkg::OffsetMax);
        send_req(ioct_pkg::ReqCommit, '0);
        send_req(ioct_tb_pkg::ReqUnused, '0);
        in_ch.valid <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d requests (%0d random) over 4 idle/stall mixes, %0d results checked",
                 sb.n_req, random_sent, sb.n_checked);
        $display("full-table refusals: %0d, acks that freed an entry: %0d, mismatches: %0d",
                 sb.n_refused, sb.n_ack_hit, sb.n_mismatch);
        if (sb.n_mismatch == 0)
            $display("inflight_offset_commit_tracker verification clean");
        else
            $display("inflight_offset_commit_tracker verification failed");
        $finish;
    end

endmodule
